// ----- rtl/core/esc_srdl_pkg.sv -----
// Package for the start ramp duty limiter: types, register map, codes and constants.
// Used by esc_srdl_cfg, esc_srdl_step and esc_start_ramp_duty_limiter_unit.
package esc_srdl_pkg;

	// Fixed behaviour constants
	localparam logic [7:0]  FAIL_STEP      = 8'd16;
	localparam logic [3:0]  TIMEOUT_RELOAD = 4'd2;
	localparam logic [3:0]  TIMEOUT_MAX    = 4'd12;
	localparam int unsigned CLOCK_MHZ      = 16;

	// PWM is halved in startup when the PWM span * 16 is below this
	localparam logic [19:0] SLOW_LIMIT = 20'(1700 * CLOCK_MHZ);

	// Divide by three as a multiply by a reciprocal (exact for the 13-bit range used)
	localparam logic [16:0] RECIP3       = 17'd43691;
	localparam int unsigned RECIP3_SHIFT = 17;

	// Register reset values
	localparam logic [15:0] RST_PWM_SPAN         = 16'd800;
	localparam logic [15:0] RST_RUN_CEIL_MAX     = 16'd799;
	localparam logic [15:0] RST_START_CEIL_MAX   = 16'd200;
	localparam logic [15:0] RST_START_MIN_POWER  = 16'd133;
	localparam logic [15:0] RST_COOL_START_POWER = 16'd33;
	localparam logic [7:0]  RST_GOOD_CYCLES      = 8'd12;
	localparam logic [7:0]  RST_MOD_STEP         = 8'd4;
	localparam logic [7:0]  RST_MOD_LIMIT        = 8'd48;
	localparam logic [10:0] RST_STEP48 = 11'((800 + 47) / 48);
	localparam logic [11:0] RST_STEP32 = 12'((800 + 31) / 32);
	localparam logic        RST_SLOW_PWM = (800 * 16) < (1700 * CLOCK_MHZ);

	typedef enum logic [2:0] {
		REG_PWM_SPAN         = 3'd0,
		REG_RUN_CEIL_MAX     = 3'd1,
		REG_START_CEIL_MAX   = 3'd2,
		REG_START_MIN_POWER  = 3'd3,
		REG_COOL_START_POWER = 3'd4,
		REG_GOOD_CYCLES      = 3'd5,
		REG_MOD_STEP         = 3'd6,
		REG_MOD_LIMIT        = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_COMMUT   = 2'd0,
		KIND_THROTTLE = 2'd1,
		KIND_RESTART  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ACT_CONTINUE     = 2'd0,
		ACT_RESTART_CTRL = 2'd1,
		ACT_RESTART_RUN  = 2'd2,
		ACT_START_FAILED = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		PWM_OFF       = 2'd0,
		PWM_SHORT_OFF = 2'd1,
		PWM_LONG_OFF  = 2'd2
	} pwm_mode_t;

	// Configuration seen by the step logic, with the derived ramp steps
	typedef struct packed {
		logic [15:0] pwm_span;
		logic [15:0] run_ceil_max;
		logic [15:0] start_ceil_max;
		logic [15:0] start_min_power;
		logic [15:0] cool_start_power;
		logic [7:0]  good_cycles_needed;
		logic [7:0]  modulation_step;
		logic [7:0]  modulation_limit;
		logic [10:0] step48;
		logic [11:0] step32;
		logic        slow_pwm;
	} cfg_t;

	// One result word
	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] duty_word;
		logic [15:0] off_duty_word;
		logic [1:0]  pwm_mode;
		logic        full_duty;
		logic        power_enabled;
		logic [15:0] power_ceiling;
		logic [3:0]  timeout_count;
	} res_t;

endpackage

// ----- rtl/core/esc_srdl_cfg.sv -----
// Configuration register bank of the start ramp duty limiter, with derived ramp steps.
// Depends on esc_srdl_pkg.
module esc_srdl_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output esc_srdl_pkg::cfg_t  cfg
);

	logic                        wr_en;
	esc_srdl_pkg::reg_idx_t      idx;
	logic [16:0]                 pr_plus47;
	logic [29:0]                 div3_prod;
	logic [16:0]                 pr_plus31;
	logic [10:0]                 step48_d;
	logic [11:0]                 step32_d;
	logic                        slow_d;
	esc_srdl_pkg::cfg_t          cfg_q;

	assign wr_en = psel & penable & pwrite;
	assign idx   = esc_srdl_pkg::reg_idx_t'(paddr[4:2]);

	// Derive ramp steps from the PWM span being written
	always_comb begin
		pr_plus47 = {1'b0, pwdata[15:0]} + 17'd47;
		div3_prod = 30'(pr_plus47[16:4]) * 30'(esc_srdl_pkg::RECIP3);
		step48_d  = div3_prod[esc_srdl_pkg::RECIP3_SHIFT +: 11];
		pr_plus31 = {1'b0, pwdata[15:0]} + 17'd31;
		step32_d  = pr_plus31[16:5];
		slow_d    = {pwdata[15:0], 4'b0000} < esc_srdl_pkg::SLOW_LIMIT;
	end

	// Hold the registers; write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_span           <= esc_srdl_pkg::RST_PWM_SPAN;
			cfg_q.run_ceil_max       <= esc_srdl_pkg::RST_RUN_CEIL_MAX;
			cfg_q.start_ceil_max     <= esc_srdl_pkg::RST_START_CEIL_MAX;
			cfg_q.start_min_power    <= esc_srdl_pkg::RST_START_MIN_POWER;
			cfg_q.cool_start_power   <= esc_srdl_pkg::RST_COOL_START_POWER;
			cfg_q.good_cycles_needed <= esc_srdl_pkg::RST_GOOD_CYCLES;
			cfg_q.modulation_step    <= esc_srdl_pkg::RST_MOD_STEP;
			cfg_q.modulation_limit   <= esc_srdl_pkg::RST_MOD_LIMIT;
			cfg_q.step48             <= esc_srdl_pkg::RST_STEP48;
			cfg_q.step32             <= esc_srdl_pkg::RST_STEP32;
			cfg_q.slow_pwm           <= esc_srdl_pkg::RST_SLOW_PWM;
		end else if (wr_en) begin
			case (idx)
				esc_srdl_pkg::REG_PWM_SPAN: begin
					cfg_q.pwm_span <= pwdata[15:0];
					cfg_q.step48   <= step48_d;
					cfg_q.step32   <= step32_d;
					cfg_q.slow_pwm <= slow_d;
				end
				esc_srdl_pkg::REG_RUN_CEIL_MAX:     cfg_q.run_ceil_max <= pwdata[15:0];
				esc_srdl_pkg::REG_START_CEIL_MAX:   cfg_q.start_ceil_max <= pwdata[15:0];
				esc_srdl_pkg::REG_START_MIN_POWER:  cfg_q.start_min_power <= pwdata[15:0];
				esc_srdl_pkg::REG_COOL_START_POWER: cfg_q.cool_start_power <= pwdata[15:0];
				esc_srdl_pkg::REG_GOOD_CYCLES:      cfg_q.good_cycles_needed <= pwdata[7:0];
				esc_srdl_pkg::REG_MOD_STEP:         cfg_q.modulation_step <= pwdata[7:0];
				esc_srdl_pkg::REG_MOD_LIMIT:        cfg_q.modulation_limit <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			esc_srdl_pkg::REG_PWM_SPAN:         prdata = {16'h0, cfg_q.pwm_span};
			esc_srdl_pkg::REG_RUN_CEIL_MAX:     prdata = {16'h0, cfg_q.run_ceil_max};
			esc_srdl_pkg::REG_START_CEIL_MAX:   prdata = {16'h0, cfg_q.start_ceil_max};
			esc_srdl_pkg::REG_START_MIN_POWER:  prdata = {16'h0, cfg_q.start_min_power};
			esc_srdl_pkg::REG_COOL_START_POWER: prdata = {16'h0, cfg_q.cool_start_power};
			esc_srdl_pkg::REG_GOOD_CYCLES:      prdata = {24'h0, cfg_q.good_cycles_needed};
			esc_srdl_pkg::REG_MOD_STEP:         prdata = {24'h0, cfg_q.modulation_step};
			esc_srdl_pkg::REG_MOD_LIMIT:        prdata = {24'h0, cfg_q.modulation_limit};
			default:                            prdata = 32'h0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/esc_srdl_step.sv -----
// Governor state and the single-pass update logic for one word.
// Depends on esc_srdl_pkg.
module esc_srdl_step (
	input  logic                clk,
	input  logic                arst_n,
	input  esc_srdl_pkg::cfg_t  cfg,
	input  logic                adv,
	input  logic [1:0]          kind,
	input  logic [15:0]         throttle,
	input  logic [15:0]         timing_limit,
	input  logic                set_enable,
	output esc_srdl_pkg::res_t  res
);

	logic [15:0] ceiling_q;
	logic [7:0]  good_q, mod_q, fail_q;
	logic        startup_q, powered_q, full_q;
	logic [3:0]  tticks_q;
	logic [15:0] on_q, off_q;
	logic [1:0]  mode_q;

	logic [15:0] ceiling_d;
	logic [7:0]  good_d, mod_d, fail_d;
	logic        startup_d, powered_d, full_d;
	logic [3:0]  tticks_d;
	logic [15:0] on_d, off_d;
	logic [1:0]  mode_d;
	logic [1:0]  action_d;

	logic [16:0] sum32, sum48;
	logic [15:0] copy32, copy48;
	logic [7:0]  mod_new, fail_new;
	logic [15:0] d_lim, d_cap, d_floor, off_raw;
	logic [16:0] dbl;

	always_comb begin
		// Ramp candidates
		sum32  = {1'b0, ceiling_q} + 17'(cfg.step32);
		copy32 = sum32[16] ? 16'hFFFF : sum32[15:0];
		sum48  = {1'b0, ceiling_q} + 17'(cfg.step48);
		copy48 = sum48[16] ? 16'hFFFF : sum48[15:0];
		mod_new  = mod_q + cfg.modulation_step;
		fail_new = fail_q + esc_srdl_pkg::FAIL_STEP;

		// Duty clamp chain
		d_lim   = (timing_limit <= throttle) ? timing_limit : throttle;
		d_cap   = (ceiling_q <= d_lim) ? ceiling_q : d_lim;
		d_floor = (cfg.start_min_power <= d_cap) ? d_cap : cfg.start_min_power;
		dbl     = {d_floor, 1'b0};
		off_raw = (d_cap >= cfg.start_ceil_max) ? 16'h0 : (cfg.start_ceil_max - d_cap);

		// Hold by default
		ceiling_d = ceiling_q;
		good_d    = good_q;
		mod_d     = mod_q;
		fail_d    = fail_q;
		startup_d = startup_q;
		powered_d = powered_q;
		full_d    = full_q;
		tticks_d  = tticks_q;
		on_d      = on_q;
		off_d     = off_q;
		mode_d    = mode_q;
		action_d  = esc_srdl_pkg::ACT_CONTINUE;

		case (esc_srdl_pkg::kind_t'(kind))
			esc_srdl_pkg::KIND_COMMUT: begin
				if ((!powered_q && good_q == 8'd0) || ceiling_q == 16'd0) begin
					// Restart: switch power off and re-arm
					action_d  = (!powered_q && good_q == 8'd0) ?
						esc_srdl_pkg::ACT_RESTART_CTRL : esc_srdl_pkg::ACT_RESTART_RUN;
					on_d      = 16'h0;
					off_d     = 16'h0;
					mode_d    = esc_srdl_pkg::PWM_OFF;
					powered_d = 1'b0;
					full_d    = 1'b0;
					ceiling_d = cfg.start_min_power;
					mod_d     = 8'd0;
					fail_d    = 8'd0;
					good_d    = cfg.good_cycles_needed;
					tticks_d  = esc_srdl_pkg::TIMEOUT_RELOAD;
				end else if (good_q >= cfg.good_cycles_needed) begin
					// Running: leave startup and ramp to the running ceiling
					startup_d = 1'b0;
					fail_d    = 8'd0;
					mod_d     = 8'd0;
					ceiling_d = (copy32 < cfg.run_ceil_max) ? copy32 : cfg.run_ceil_max;
				end else begin
					// Startup ramp with modulation and failure count
					good_d = good_q + 8'd1;
					mod_d  = mod_new;
					if (mod_new == 8'd0 && fail_new == 8'd0) begin
						action_d = esc_srdl_pkg::ACT_START_FAILED;
					end else begin
						if (mod_new == 8'd0) begin
							fail_d = fail_new;
						end
						if (esc_srdl_pkg::FAIL_STEP > ((mod_new == 8'd0) ? fail_new : fail_q)
							|| cfg.modulation_limit > mod_new) begin
							ceiling_d = (copy48 < cfg.start_ceil_max) ?
								copy48 : cfg.start_ceil_max;
						end else begin
							ceiling_d = (copy48 < cfg.cool_start_power) ?
								copy48 : cfg.cool_start_power;
						end
					end
				end
			end
			esc_srdl_pkg::KIND_THROTTLE: begin
				if (set_enable) begin
					tticks_d = esc_srdl_pkg::TIMEOUT_RELOAD;
					if (dbl <= {1'b0, ceiling_q}) begin
						ceiling_d = dbl[15:0];
					end
					if (off_raw == 16'h0) begin
						full_d    = 1'b1;
						powered_d = 1'b1;
						on_d      = d_cap;
						off_d     = 16'h0;
						mode_d    = esc_srdl_pkg::PWM_SHORT_OFF;
					end else if (d_cap == 16'h0) begin
						full_d    = 1'b0;
						powered_d = 1'b0;
						on_d      = 16'h0;
						off_d     = off_raw;
						mode_d    = esc_srdl_pkg::PWM_OFF;
					end else begin
						full_d    = 1'b0;
						powered_d = 1'b1;
						// Halve the PWM frequency in startup on a short period
						if (cfg.slow_pwm && startup_q) begin
							on_d  = d_cap[15] ? 16'hFFFF : {d_cap[14:0], 1'b0};
							off_d = off_raw[15] ? 16'hFFFF : {off_raw[14:0], 1'b0};
						end else begin
							on_d  = d_cap;
							off_d = off_raw;
						end
						mode_d = (off_d[15:8] != 8'h0) ?
							esc_srdl_pkg::PWM_LONG_OFF : esc_srdl_pkg::PWM_SHORT_OFF;
					end
				end else if (tticks_q < esc_srdl_pkg::TIMEOUT_MAX) begin
					tticks_d = tticks_q + 4'd1;
				end
			end
			esc_srdl_pkg::KIND_RESTART: begin
				action_d  = esc_srdl_pkg::ACT_RESTART_RUN;
				on_d      = 16'h0;
				off_d     = 16'h0;
				mode_d    = esc_srdl_pkg::PWM_OFF;
				powered_d = 1'b0;
				full_d    = 1'b0;
				ceiling_d = cfg.start_min_power;
				mod_d     = 8'd0;
				fail_d    = 8'd0;
				good_d    = cfg.good_cycles_needed;
				tticks_d  = esc_srdl_pkg::TIMEOUT_RELOAD;
			end
			default: begin
			end
		endcase
	end

	// Advance the state with each word that moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= esc_srdl_pkg::RST_START_MIN_POWER;
			good_q    <= 8'd0;
			mod_q     <= 8'd0;
			fail_q    <= 8'd0;
			startup_q <= 1'b1;
			powered_q <= 1'b0;
			full_q    <= 1'b0;
			tticks_q  <= 4'd0;
			on_q      <= 16'h0;
			off_q     <= 16'h0;
			mode_q    <= esc_srdl_pkg::PWM_OFF;
		end else if (adv) begin
			ceiling_q <= ceiling_d;
			good_q    <= good_d;
			mod_q     <= mod_d;
			fail_q    <= fail_d;
			startup_q <= startup_d;
			powered_q <= powered_d;
			full_q    <= full_d;
			tticks_q  <= tticks_d;
			on_q      <= on_d;
			off_q     <= off_d;
			mode_q    <= mode_d;
		end
	end

	// Result reports the state after the step, duty low bytes inverted
	always_comb begin
		res.action        = action_d;
		res.duty_word     = {on_d[15:8], ~on_d[7:0]};
		res.off_duty_word = {off_d[15:8], ~off_d[7:0]};
		res.pwm_mode      = mode_d;
		res.full_duty     = full_d;
		res.power_enabled = powered_d;
		res.power_ceiling = ceiling_d;
		res.timeout_count = tticks_d;
	end

endmodule

// ----- rtl/core/esc_start_ramp_duty_limiter_unit.sv -----
// Start ramp duty limiter, top level: input register, step logic, result register.
// A word goes through the input register, then the result register, to the master side.
// Throughput: one word per cycle while m_tready does not stall the output; the governor
// state updates in the same cycle the result register loads; the next input word sees it.
// Reset (arst_n low, asynchronous): both stages empty, governor state and
// configuration registers return to their defaults. Depends on esc_srdl_pkg.
module esc_start_ramp_duty_limiter_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [15:0] throttle, [31:16] timing_limit, [32] set_enable
	input  logic [1:0]  s_tuser,  // [1:0] kind
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // [15:0] duty_word, [31:16] off_duty_word, [33:32] pwm_mode,
	                              // [34] full_duty, [35] power_enabled,
	                              // [51:36] power_ceiling, [55:52] timeout_count
	output logic [1:0]  m_tuser,  // [1:0] action
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	esc_srdl_pkg::cfg_t cfg;
	esc_srdl_pkg::res_t res;
	esc_srdl_pkg::res_t res_q;

	logic        s1_valid_q;
	logic [1:0]  kind_s1;
	logic [15:0] throttle_s1;
	logic [15:0] tlim_s1;
	logic        en_s1;
	logic        out_valid_q;
	logic        adv;
	logic        s_fire;

	assign pready = 1'b1;

	esc_srdl_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	// Advance when the result register is free or being drained
	assign adv      = s1_valid_q & (~out_valid_q | m_tready);
	assign s_tready = ~s1_valid_q | adv;
	assign s_fire   = s_tvalid & s_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= s_fire | (s1_valid_q & ~adv);
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			kind_s1     <= s_tuser;
			throttle_s1 <= s_tdata[15:0];
			tlim_s1     <= s_tdata[31:16];
			en_s1       <= s_tdata[32];
		end
	end

	esc_srdl_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.adv         (adv),
		.kind        (kind_s1),
		.throttle    (throttle_s1),
		.timing_limit(tlim_s1),
		.set_enable  (en_s1),
		.res         (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= adv | (out_valid_q & ~m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.action;
	assign m_tdata  = {res_q.timeout_count, res_q.power_ceiling, res_q.power_enabled,
		res_q.full_duty, res_q.pwm_mode, res_q.off_duty_word, res_q.duty_word};

`ifndef NO_ASSERTIONS
	// Timeout counter never passes its hold value
	a_timeout_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_q.timeout_count <= esc_srdl_pkg::TIMEOUT_MAX)
		else $error("timeout count above hold value");

	// Full duty is only reported with power enabled
	a_full_powered: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.full_duty) |-> res_q.power_enabled)
		else $error("full duty without power enabled");

	// PWM off exactly when power is disabled
	a_mode_power: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((res_q.pwm_mode == esc_srdl_pkg::PWM_OFF) == !res_q.power_enabled))
		else $error("pwm mode disagrees with power enable");

	// A restart switches the on duty off
	a_restart_off: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (res_q.action == esc_srdl_pkg::ACT_RESTART_CTRL
			|| res_q.action == esc_srdl_pkg::ACT_RESTART_RUN))
		|-> (res_q.duty_word == 16'h00FF && !res_q.power_enabled))
		else $error("restart left duty on");

	// Input stage only drains into a result register that is free or being drained
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready && s1_valid_q) |=> (s1_valid_q && $stable(res_q)))
		else $error("result overwritten while stalled");
`endif

endmodule
